// ----- sv/gic_pkg.sv -----
// ---------------------------------------------------------------------------
// Gamepad input conditioner package
// Shared types, constants and the axis conditioning table.
// ---------------------------------------------------------------------------
package gic_pkg;

  localparam int unsigned AxisW       = 8;
  localparam int unsigned AxisLanes   = 4;
  localparam int unsigned HoldLanes   = 4;
  localparam int unsigned EdgeLanes   = 4;
  localparam int unsigned ButtonW     = 10;
  localparam int unsigned ElapsedW    = 10;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned MagW        = 7;
  localparam int unsigned LutDepth    = 129;
  localparam int unsigned InDataW     = 56;
  localparam int unsigned OutDataW    = 48;
  localparam logic [TimeW-1:0] HoldTimeReset = 16'd1500;

  // Button positions within the mask.
  localparam int unsigned BtnEdgeLo = 4;
  localparam int unsigned BtnStart  = 8;
  localparam int unsigned BtnSelect = 9;

  typedef logic [MagW-1:0] axis_lut_t [LutDepth];

  // Magnitude of the centred axis (0..128) to the conditioned percent
  // magnitude: scale to percent, drop the dead zone, stretch the rest.
  function automatic axis_lut_t build_axis_lut();
    axis_lut_t lut;
    int        pct;
    int        q;
    for (int i = 0; i < LutDepth; i++) begin
      pct = (i * 100) / 128;
      if (pct < 10) begin
        q = 0;
      end else begin
        q = ((pct - 10) * 100) / 90;
      end
      lut[i] = MagW'(q);
    end
    return lut;
  endfunction

  localparam axis_lut_t AxisLut = build_axis_lut();

  // Per-lane control for the hold timers.
  typedef struct packed {
    logic                step;
    logic                pressed;
    logic [ElapsedW-1:0] elapsed;
  } hold_ctrl_t;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    logic                   menu_request;
    logic                   emergency_stop;
    logic [EdgeLanes-1:0]   edge_pulses;
    logic [HoldLanes-1:0]   hold_flags;
    logic signed [AxisW-1:0] left_right;
    logic signed [AxisW-1:0] fore_back;
    logic signed [AxisW-1:0] yaw_rate;
    logic signed [AxisW-1:0] up_down;
  } result_t;

endpackage

// ----- sv/gic_axis_lane.sv -----
// ---------------------------------------------------------------------------
// Axis lane
// Centres one raw stick axis, applies the dead zone and rescaling, and
// optionally negates the result.
// ---------------------------------------------------------------------------
module gic_axis_lane (
  input  logic [gic_pkg::AxisW-1:0]        raw_i,
  input  logic                             invert_i,
  output logic signed [gic_pkg::AxisW-1:0] axis_o
);

  logic                        below_centre;
  logic [gic_pkg::AxisW-1:0]   mag;
  logic [gic_pkg::MagW-1:0]    q;
  logic [gic_pkg::AxisW-1:0]   q_ext;

  // Raw values under 128 lie left of centre; the magnitude reaches 128.
  assign below_centre = ~raw_i[gic_pkg::AxisW-1];
  assign mag   = below_centre ? (8'd128 - raw_i) : (raw_i - 8'd128);
  assign q     = gic_pkg::AxisLut[mag];
  assign q_ext = {1'b0, q};

  assign axis_o = (below_centre ^ invert_i) ? signed'(-q_ext) : signed'(q_ext);

endmodule

// ----- sv/gic_hold_lane.sv -----
// ---------------------------------------------------------------------------
// Hold lane
// Hold timer and hold flag for one button.
// ---------------------------------------------------------------------------
module gic_hold_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gic_pkg::hold_ctrl_t        ctrl_i,
  input  logic [gic_pkg::TimeW-1:0]  hold_time_i,
  output logic                       flag_o
);

  logic [gic_pkg::TimeW-1:0] timer_q, timer_d;
  logic                      flag_q, flag_d;
  logic [gic_pkg::TimeW:0]   sum;

  // One bit wider than the timer, so the stored value never wraps.
  assign sum = {1'b0, timer_q} + {{(gic_pkg::TimeW + 1 - gic_pkg::ElapsedW){1'b0}},
                                  ctrl_i.elapsed};

  always_comb begin
    timer_d = '0;
    flag_d  = 1'b0;
    if (ctrl_i.pressed) begin
      if (sum >= {1'b0, hold_time_i}) begin
        flag_d = 1'b1;
      end else begin
        timer_d = sum[gic_pkg::TimeW-1:0];
        flag_d  = flag_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      flag_q  <= 1'b0;
    end else if (ctrl_i.step) begin
      timer_q <= timer_d;
      flag_q  <= flag_d;
    end
  end

  assign flag_o = flag_d;

endmodule

// ----- sv/gamepad_input_conditioner.sv -----
// ---------------------------------------------------------------------------
// Gamepad input conditioner
// Conditions pad samples: four stick axes, hold timers, edge pulses and the
// start/select decode, one result item per input item.
//
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid/tready            tdata: lsx, lsy, rsx, rsy, buttons, elapsed
// m_axis    out  tvalid/tready            tdata: result fields
// cfg       in   cfg_we_i (no wait)       cfg_wdata_i: hold_time_ms
//
// An item is taken every cycle while the skid register is empty; its result
// goes to the output register, or to the skid register while the output is
// stalled. Four axis lanes and four hold lanes work in parallel ahead of
// these registers. The skid register keeps input acceptance going for one
// item while the output is stalled. Reset clears timers, flags, edge history
// and valids, and sets hold_time_ms to 1500.
// ---------------------------------------------------------------------------
module gamepad_input_conditioner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] left_stick_x, [15:8] left_stick_y, [23:16] right_stick_x,
  // [31:24] right_stick_y, [41:32] button_mask, [51:42] elapsed_ms, rest zero
  input  logic [gic_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] up_down, [15:8] yaw_rate, [23:16] fore_back, [31:24] left_right,
  // [35:32] hold_flags, [39:36] edge_pulses, [40] emergency_stop,
  // [41] menu_request, rest zero
  output logic [gic_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [gic_pkg::TimeW-1:0]     cfg_wdata_i
);

  logic [gic_pkg::TimeW-1:0]     hold_time_q;
  logic [gic_pkg::ButtonW-1:0]   buttons;
  logic [gic_pkg::ElapsedW-1:0]  elapsed;
  logic [gic_pkg::EdgeLanes-1:0] edge_now, prev_edge_q;
  logic [gic_pkg::HoldLanes-1:0] hold_flags;
  logic signed [gic_pkg::AxisW-1:0] axis [gic_pkg::AxisLanes];
  logic                          s_accept, out_take;
  gic_pkg::result_t              result_d;
  gic_pkg::result_t              out_q, skid_q;
  logic                          out_valid_q, skid_valid_q;

  assign buttons  = s_axis_tdata_i[41:32];
  assign elapsed  = s_axis_tdata_i[51:42];
  assign s_accept = s_axis_tvalid_i & s_axis_tready_o;
  assign out_take = out_valid_q & m_axis_tready_i;

  // Lanes in item order: left x, left y, right x, right y.
  for (genvar g = 0; g < gic_pkg::AxisLanes; g++) begin : g_axis
    gic_axis_lane u_axis (
      .raw_i    (s_axis_tdata_i[g*gic_pkg::AxisW +: gic_pkg::AxisW]),
      .invert_i (g[0] == 1'b1),
      .axis_o   (axis[g])
    );
  end

  for (genvar g = 0; g < gic_pkg::HoldLanes; g++) begin : g_hold
    gic_pkg::hold_ctrl_t ctrl;
    assign ctrl.step    = s_accept;
    assign ctrl.pressed = buttons[g];
    assign ctrl.elapsed = elapsed;
    gic_hold_lane u_hold (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .hold_time_i (hold_time_q),
      .flag_o      (hold_flags[g])
    );
  end

  assign edge_now = buttons[gic_pkg::BtnEdgeLo +: gic_pkg::EdgeLanes];

  // Merge the lane outputs into one result item.
  always_comb begin
    result_d.up_down        = axis[1];
    result_d.yaw_rate       = axis[0];
    result_d.fore_back      = axis[3];
    result_d.left_right     = axis[2];
    result_d.hold_flags     = hold_flags;
    result_d.edge_pulses    = edge_now & ~prev_edge_q;
    result_d.emergency_stop = buttons[gic_pkg::BtnStart] & buttons[gic_pkg::BtnSelect];
    result_d.menu_request   = ~buttons[gic_pkg::BtnStart] & buttons[gic_pkg::BtnSelect];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= gic_pkg::HoldTimeReset;
    end else if (cfg_we_i) begin
      hold_time_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_edge_q <= '0;
    end else if (s_accept) begin
      prev_edge_q <= edge_now;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= s_accept;
      end
    end else if (s_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (s_accept) begin
        out_q <= result_d;
      end
    end else if (s_accept) begin
      skid_q <= result_d;
    end
  end

  assign s_axis_tready_o = ~skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(gic_pkg::OutDataW - $bits(gic_pkg::result_t)){1'b0}}, out_q};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && s_accept) |=> (skid_valid_q && out_valid_q))
    else $error("item accepted during an output stall was not kept");

  a_release_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !buttons[0] && (!out_valid_q || out_take) && !skid_valid_q)
      |=> !out_q.hold_flags[0])
    else $error("hold flag set for a released button");
`endif

endmodule
